// ----- src/sd_spi_command_engine_core_assert.svh -----
// Assertion macros shared by the command engine modules.
`ifndef SD_SPI_COMMAND_ENGINE_CORE_ASSERT_SVH
`define SD_SPI_COMMAND_ENGINE_CORE_ASSERT_SVH
// Checks that a condition implies another at the same edge.
`define SDE_ASSERT_IMP(label, clk, rstn, cond, prop) \
    label: assert property (@(posedge clk) disable iff (!rstn) (cond) |-> (prop)) \
        else $error("assertion failed");
// Checks that a condition implies another at the next edge.
`define SDE_ASSERT_NEXT(label, clk, rstn, cond, prop) \
    label: assert property (@(posedge clk) disable iff (!rstn) (cond) |=> (prop)) \
        else $error("assertion failed");
`endif

// ----- src/sde_pkg.sv -----
// Package with types, constants and helpers of the SD SPI command engine.
package sde_pkg;
    localparam int WriteBlockBytes = 512;
    localparam int InWidth = 2 + 6 + 1 + 32 + 8 + 13 + 8 + 8;
    localparam int OutWidth = 1 + 8 + 1 + 1 + 1 + 8 + 1 + 3 + 8;

    typedef enum logic [1:0] {
        OP_CMD = 2'd0,
        OP_READ = 2'd1,
        OP_WRITE = 2'd2,
        OP_XCHG = 2'd3
    } op_t;

    typedef enum logic [1:0] {
        REG_READY_LIMIT = 2'd0,
        REG_TOKEN_LIMIT = 2'd1,
        REG_RESPONSE_LIMIT = 2'd2
    } reg_index_t;

    typedef enum logic [2:0] {
        ST_OK = 3'd0,
        ST_NOT_READY = 3'd1,
        ST_BAD_TOKEN = 3'd2,
        ST_REJECTED = 3'd3,
        ST_BUSY = 3'd4
    } status_t;

    typedef enum logic [17:0] {
        PH_IDLE = 18'd1 << 0,
        PH_DESEL = 18'd1 << 1,
        PH_SELDUM = 18'd1 << 2,
        PH_READY = 18'd1 << 3,
        PH_FAILDES = 18'd1 << 4,
        PH_CMDTX = 18'd1 << 5,
        PH_DISCARD = 18'd1 << 6,
        PH_RESP = 18'd1 << 7,
        PH_TOKEN = 18'd1 << 8,
        PH_RDATA = 18'd1 << 9,
        PH_RCRC1 = 18'd1 << 10,
        PH_RCRC2 = 18'd1 << 11,
        PH_WREADY = 18'd1 << 12,
        PH_WTOKEN = 18'd1 << 13,
        PH_WDATA = 18'd1 << 14,
        PH_WCRC1 = 18'd1 << 15,
        PH_WCRC2 = 18'd1 << 16,
        PH_WRESP = 18'd1 << 17
    } phase_t;

    typedef struct packed {
        op_t         op;
        logic [5:0]  cmd_index;
        logic        app_cmd;
        logic [31:0] cmd_arg;
        logic [7:0]  block_token;
        logic [12:0] read_length;
        logic [7:0]  rx_byte;
        logic [7:0]  write_data;
    } item_t;

    typedef struct packed {
        logic       tx_valid;
        logic [7:0] tx_byte;
        logic       cs_low;
        logic       data_request;
        logic       read_valid;
        logic [7:0] read_data;
        logic       done_res;
        status_t    status;
        logic [7:0] response;
    } result_t;

    localparam logic [7:0] ByteIdle = 8'hFF;
    localparam logic [7:0] TokenStart = 8'hFE;
    localparam logic [7:0] TokenStop = 8'hFD;
    localparam logic [7:0] CmdPrefix = 8'h40;
    localparam logic [5:0] CmdGoIdle = 6'd0;
    localparam logic [5:0] CmdIfCond = 6'd8;
    localparam logic [5:0] CmdStop = 6'd12;
    localparam logic [5:0] CmdApp = 6'd55;

    function automatic logic [7:0] cmd_byte(input logic [2:0] idx, input logic [5:0] cmd,
                                            input logic [31:0] arg);
        logic [7:0] b;
        case (idx)
            3'd0: b = CmdPrefix | {2'b00, cmd};
            3'd1: b = arg[31:24];
            3'd2: b = arg[23:16];
            3'd3: b = arg[15:8];
            3'd4: b = arg[7:0];
            default: begin
                if (cmd == CmdGoIdle) b = 8'h95;
                else if (cmd == CmdIfCond) b = 8'h87;
                else b = 8'h01;
            end
        endcase
        return b;
    endfunction
endpackage

// ----- src/sde_front.sv -----
// Input stage: unpacks request items and holds them in a two-entry queue.
module sde_front (
    input  logic           aclk,
    input  logic           aresetn,
    input  logic           s_tvalid,
    output logic           s_tready,
    input  logic [79:0]    s_tdata,
    output logic           q_valid,
    input  logic           q_ready,
    output sde_pkg::item_t q_item
);
    import sde_pkg::*;
    `include "sd_spi_command_engine_core_assert.svh"

    item_t     mem_reg [2];
    logic      wr_ptr_reg, wr_ptr_next, rd_ptr_reg, rd_ptr_next;
    logic [1:0] count_reg, count_next;
    item_t     in_item;
    logic      push, pop;

    assign in_item.op = op_t'(s_tdata[1:0]);
    assign in_item.cmd_index = s_tdata[7:2];
    assign in_item.app_cmd = s_tdata[8];
    assign in_item.cmd_arg = s_tdata[40:9];
    assign in_item.block_token = s_tdata[48:41];
    assign in_item.read_length = s_tdata[61:49];
    assign in_item.rx_byte = s_tdata[69:62];
    assign in_item.write_data = s_tdata[77:70];

    assign s_tready = (count_reg != 2'd2);
    assign q_valid = (count_reg != 2'd0);
    assign q_item = mem_reg[rd_ptr_reg];
    assign push = s_tvalid && s_tready;
    assign pop = q_valid && q_ready;

    always_comb begin
        wr_ptr_next = wr_ptr_reg ^ push;
        rd_ptr_next = rd_ptr_reg ^ pop;
        count_next = count_reg + {1'b0, push} - {1'b0, pop};
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            count_reg <= 2'd0;
        end else begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg <= count_next;
        end
        if (push) mem_reg[wr_ptr_reg] <= in_item;
    end

    `SDE_ASSERT_IMP(a_no_overflow, aclk, aresetn, count_reg == 2'd2, !push)
    `SDE_ASSERT_NEXT(a_count_up, aclk, aresetn, push && !pop, count_reg == $past(count_reg) + 2'd1)
    `SDE_ASSERT_IMP(a_count_range, aclk, aresetn, 1'b1, count_reg != 2'd3)
endmodule

// ----- src/sde_back.sv -----
// Execution stage: the command state machine and its result register.
module sde_back (
    input  logic             aclk,
    input  logic             aresetn,
    input  logic             q_valid,
    output logic             q_ready,
    input  sde_pkg::item_t   q_item,
    input  logic [9:0]       ready_limit,
    input  logic [9:0]       token_limit,
    input  logic [7:0]       response_limit,
    output logic             res_valid,
    input  logic             res_ready,
    output sde_pkg::result_t res
);
    import sde_pkg::*;
    `include "sd_spi_command_engine_core_assert.svh"

    phase_t      phase_reg, phase_next;
    logic [5:0]  cmd_reg, cmd_next;
    logic        prefix_reg, prefix_next;
    logic [31:0] arg_reg, arg_next;
    logic [7:0]  token_reg, token_next;
    logic [12:0] count_reg, count_next;
    logic [9:0]  poll_reg, poll_next;
    logic        sel_reg, sel_next;
    logic        res_valid_reg;
    result_t     res_reg, r;
    logic        take;
    logic [5:0]  cur_cmd;
    logic [31:0] cur_arg;
    logic [9:0]  poll_dec;
    logic [7:0]  rx;

    assign q_ready = !res_valid_reg || res_ready;
    assign take = q_valid && q_ready;
    assign res_valid = res_valid_reg;
    assign res = res_reg;
    assign rx = q_item.rx_byte;

    always_comb begin
        cur_cmd = prefix_reg ? CmdApp : cmd_reg;
        cur_arg = prefix_reg ? 32'd0 : arg_reg;
        poll_dec = poll_reg - 10'd1;
        phase_next = phase_reg;
        cmd_next = cmd_reg;
        prefix_next = prefix_reg;
        arg_next = arg_reg;
        token_next = token_reg;
        count_next = count_reg;
        poll_next = poll_reg;
        sel_next = sel_reg;
        r = '0;
        if (q_item.op == OP_XCHG) begin
            case (phase_reg)
                PH_DESEL: begin
                    sel_next = 1'b1;
                    phase_next = PH_SELDUM;
                    r.tx_valid = 1'b1; r.tx_byte = ByteIdle;
                end
                PH_SELDUM: begin
                    poll_next = ready_limit;
                    phase_next = PH_READY;
                    r.tx_valid = 1'b1; r.tx_byte = ByteIdle;
                end
                PH_READY: begin
                    poll_next = poll_dec;
                    r.tx_valid = 1'b1; r.tx_byte = ByteIdle;
                    if (rx == ByteIdle) begin
                        phase_next = PH_CMDTX;
                        count_next = '0;
                        r.tx_byte = cmd_byte(3'd0, cur_cmd, cur_arg);
                    end else if (poll_dec == '0) begin
                        sel_next = 1'b0;
                        phase_next = PH_FAILDES;
                    end
                end
                PH_FAILDES: begin
                    prefix_next = 1'b0;
                    r.done_res = 1'b1; r.status = ST_NOT_READY; r.response = ByteIdle;
                    phase_next = PH_IDLE;
                end
                PH_CMDTX: begin
                    count_next = count_reg + 13'd1;
                    r.tx_valid = 1'b1; r.tx_byte = ByteIdle;
                    if (count_next < 13'd6) begin
                        r.tx_byte = cmd_byte(count_next[2:0], cur_cmd, cur_arg);
                    end else if (cur_cmd == CmdStop) begin
                        phase_next = PH_DISCARD;
                    end else begin
                        poll_next = {2'b00, response_limit};
                        phase_next = PH_RESP;
                    end
                end
                PH_DISCARD: begin
                    poll_next = {2'b00, response_limit};
                    phase_next = PH_RESP;
                    r.tx_valid = 1'b1; r.tx_byte = ByteIdle;
                end
                PH_RESP: begin
                    poll_next = {2'b00, poll_dec[7:0]};
                    if (rx[7] && poll_dec[7:0] != 8'd0) begin
                        r.tx_valid = 1'b1; r.tx_byte = ByteIdle;
                    end else if (prefix_reg && rx <= 8'd1) begin
                        prefix_next = 1'b0;
                        r.tx_valid = 1'b1;
                        if (cmd_reg == CmdStop) begin
                            phase_next = PH_CMDTX;
                            count_next = '0;
                            r.tx_byte = cmd_byte(3'd0, cmd_reg, arg_reg);
                        end else begin
                            sel_next = 1'b0;
                            phase_next = PH_DESEL;
                            r.tx_byte = ByteIdle;
                        end
                    end else begin
                        prefix_next = 1'b0;
                        r.done_res = 1'b1; r.status = ST_OK; r.response = rx;
                        phase_next = PH_IDLE;
                    end
                end
                PH_TOKEN: begin
                    poll_next = poll_dec;
                    if (rx == ByteIdle && poll_dec != '0) begin
                        r.tx_valid = 1'b1; r.tx_byte = ByteIdle;
                    end else if (rx != TokenStart) begin
                        r.done_res = 1'b1; r.status = ST_BAD_TOKEN;
                        phase_next = PH_IDLE;
                    end else begin
                        phase_next = (count_reg == '0) ? PH_RCRC1 : PH_RDATA;
                        r.tx_valid = 1'b1; r.tx_byte = ByteIdle;
                    end
                end
                PH_RDATA: begin
                    r.read_valid = 1'b1; r.read_data = rx;
                    count_next = count_reg - 13'd1;
                    if (count_next == '0) phase_next = PH_RCRC1;
                    r.tx_valid = 1'b1; r.tx_byte = ByteIdle;
                end
                PH_RCRC1: begin
                    phase_next = PH_RCRC2;
                    r.tx_valid = 1'b1; r.tx_byte = ByteIdle;
                end
                PH_RCRC2: begin
                    r.done_res = 1'b1; r.status = ST_OK;
                    phase_next = PH_IDLE;
                end
                PH_WREADY: begin
                    poll_next = poll_dec;
                    if (rx == ByteIdle) begin
                        phase_next = PH_WTOKEN;
                        r.tx_valid = 1'b1; r.tx_byte = token_reg;
                        r.data_request = (token_reg != TokenStop);
                    end else if (poll_dec == '0) begin
                        r.done_res = 1'b1; r.status = ST_NOT_READY;
                        phase_next = PH_IDLE;
                    end else begin
                        r.tx_valid = 1'b1; r.tx_byte = ByteIdle;
                    end
                end
                PH_WTOKEN: begin
                    if (token_reg == TokenStop) begin
                        r.done_res = 1'b1; r.status = ST_OK;
                        phase_next = PH_IDLE;
                    end else begin
                        phase_next = PH_WDATA;
                        count_next = 13'd1;
                        r.tx_valid = 1'b1; r.tx_byte = q_item.write_data;
                        r.data_request = (13'd1 < 13'(WriteBlockBytes));
                    end
                end
                PH_WDATA: begin
                    r.tx_valid = 1'b1;
                    if (count_reg < 13'(WriteBlockBytes)) begin
                        r.tx_byte = q_item.write_data;
                        count_next = count_reg + 13'd1;
                        r.data_request = (count_next < 13'(WriteBlockBytes));
                    end else begin
                        phase_next = PH_WCRC1;
                        r.tx_byte = ByteIdle;
                    end
                end
                PH_WCRC1: begin
                    phase_next = PH_WCRC2;
                    r.tx_valid = 1'b1; r.tx_byte = ByteIdle;
                end
                PH_WCRC2: begin
                    phase_next = PH_WRESP;
                    r.tx_valid = 1'b1; r.tx_byte = ByteIdle;
                end
                PH_WRESP: begin
                    r.done_res = 1'b1;
                    r.status = (rx[4:0] == 5'h05) ? ST_OK : ST_REJECTED;
                    phase_next = PH_IDLE;
                end
                default: begin
                    phase_next = PH_IDLE;
                end
            endcase
        end else if (phase_reg != PH_IDLE) begin
            r.done_res = 1'b1; r.status = ST_BUSY;
        end else if (q_item.op == OP_CMD) begin
            cmd_next = q_item.cmd_index;
            prefix_next = q_item.app_cmd;
            arg_next = q_item.cmd_arg;
            r.tx_valid = 1'b1;
            if (!q_item.app_cmd && q_item.cmd_index == CmdStop) begin
                phase_next = PH_CMDTX;
                count_next = '0;
                r.tx_byte = cmd_byte(3'd0, CmdStop, q_item.cmd_arg);
            end else begin
                sel_next = 1'b0;
                phase_next = PH_DESEL;
                r.tx_byte = ByteIdle;
            end
        end else if (q_item.op == OP_READ) begin
            count_next = q_item.read_length;
            poll_next = token_limit;
            phase_next = PH_TOKEN;
            r.tx_valid = 1'b1; r.tx_byte = ByteIdle;
        end else begin
            token_next = q_item.block_token;
            poll_next = ready_limit;
            phase_next = PH_WREADY;
            r.tx_valid = 1'b1; r.tx_byte = ByteIdle;
        end
        r.cs_low = sel_next;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            phase_reg <= PH_IDLE;
            cmd_reg <= '0;
            prefix_reg <= 1'b0;
            arg_reg <= '0;
            token_reg <= '0;
            count_reg <= '0;
            poll_reg <= '0;
            sel_reg <= 1'b0;
            res_valid_reg <= 1'b0;
        end else begin
            if (take) begin
                phase_reg <= phase_next;
                cmd_reg <= cmd_next;
                prefix_reg <= prefix_next;
                arg_reg <= arg_next;
                token_reg <= token_next;
                count_reg <= count_next;
                poll_reg <= poll_next;
                sel_reg <= sel_next;
                res_valid_reg <= 1'b1;
            end else if (res_ready) begin
                res_valid_reg <= 1'b0;
            end
        end
        if (take) res_reg <= r;
    end

    `SDE_ASSERT_IMP(a_done_idle, aclk, aresetn, take && r.done_res && r.status != ST_BUSY,
        phase_next == PH_IDLE)
    `SDE_ASSERT_IMP(a_hold, aclk, aresetn, res_valid_reg && !res_ready, !q_ready)
    `SDE_ASSERT_NEXT(a_cs_follow, aclk, aresetn, take, res_reg.cs_low == sel_reg)
endmodule

// ----- src/sd_spi_command_engine_core.sv -----
// Top level of the SD card SPI-mode host command engine.
// Each request or finished byte exchange gives exactly one result; one item is taken per
// clock when the result side keeps up, with a two-entry input queue feeding a state machine
// whose result register is its single stage; an item is stored in the queue, then registered as a result.
// Configuration writes are accepted at any time and take effect for later requests.
module sd_spi_command_engine_core (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_tvalid,
    output logic        s_tready,
    // op, cmd_index, app_cmd, cmd_arg, block_token, read_length, rx_byte, write_data
    input  logic [79:0] s_tdata,
    output logic        m_tvalid,
    input  logic        m_tready,
    // tx_valid, tx_byte, cs_low, data_request, read_valid, read_data, done_res, status, response
    output logic [31:0] m_tdata,
    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic [1:0]  cfg_index,
    input  logic [9:0]  cfg_data
);
    import sde_pkg::*;

    logic       q_valid, q_ready;
    item_t      q_item;
    result_t    res;
    logic [9:0] ready_limit_reg, token_limit_reg;
    logic [7:0] response_limit_reg;

    assign cfg_ready = 1'b1;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            ready_limit_reg <= 10'd500;
            token_limit_reg <= 10'd200;
            response_limit_reg <= 8'd10;
        end else if (cfg_valid) begin
            case (reg_index_t'(cfg_index))
                REG_READY_LIMIT: ready_limit_reg <= cfg_data;
                REG_TOKEN_LIMIT: token_limit_reg <= cfg_data;
                REG_RESPONSE_LIMIT: response_limit_reg <= cfg_data[7:0];
                default: ;
            endcase
        end
    end

    sde_front u_front (
        .aclk(aclk), .aresetn(aresetn), .s_tvalid(s_tvalid), .s_tready(s_tready),
        .s_tdata(s_tdata), .q_valid(q_valid), .q_ready(q_ready), .q_item(q_item)
    );

    sde_back u_back (
        .aclk(aclk), .aresetn(aresetn), .q_valid(q_valid), .q_ready(q_ready),
        .q_item(q_item), .ready_limit(ready_limit_reg), .token_limit(token_limit_reg),
        .response_limit(response_limit_reg), .res_valid(m_tvalid), .res_ready(m_tready),
        .res(res)
    );

    assign m_tdata = {res.response, res.status, res.done_res, res.read_data,
                      res.read_valid, res.data_request, res.cs_low, res.tx_byte, res.tx_valid};
endmodule
